@@ hdl/assert_macros.svh @@
// assertion macros shared by the buffer pool frame manager rtl
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked every clock outside reset
`define BFM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define BFM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bfm_pkg.sv @@
// shared types and codes for the buffer pool frame manager
// used by bfm_lru and buffer_pool_frame_manager_unit; no dependencies
package bfm_pkg;

  // frames in the pool; the frame field of a result is four bits wide
  localparam int NUM_FRAMES = 16;

  typedef enum logic [2:0] {
    MODE_FETCH     = 3'd0,
    MODE_NEW       = 3'd1,
    MODE_UNPIN     = 3'd2,
    MODE_DELETE    = 3'd3,
    MODE_FLUSH     = 3'd4,
    MODE_FLUSH_ALL = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_RESIDENT = 2'd1,
    ST_NO_FRAME     = 2'd2,
    ST_PINNED       = 2'd3
  } status_t;

  localparam logic REG_INST_COUNT  = 1'b0;
  localparam logic REG_INST_NUMBER = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [30:0] page_id;
    logic        mark_dirty;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame;
    logic [30:0] page_out;
    logic        write_back;
    logic [30:0] write_back_page;
    logic        read_in;
    logic        last;
  } rsp_t;

  typedef enum logic [1:0] {
    LRU_REMOVE = 2'd0,
    LRU_PUSH   = 2'd1,
    LRU_POP    = 2'd2
  } lru_op_t;

  typedef struct packed {
    logic    start;
    lru_op_t op;
  } lru_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lru_stat_t;

endpackage

@@ hdl/bfm_lru.sv @@
// lru order of unpinned frames kept in a one-port-read/one-port-write memory
// depends on bfm_pkg
module bfm_lru #(
  parameter int DEPTH = 16,
  localparam int FW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  bfm_pkg::lru_cmd_t  cmd,
  input  logic [FW-1:0]      frame,
  output bfm_pkg::lru_stat_t stat,
  output logic [FW-1:0]      head,
  output logic [FW:0]        count
);

  typedef enum logic [1:0] {L_IDLE, L_SCAN, L_SHIFT} lstate_t;

  lstate_t          state;
  logic [FW-1:0]    mem [DEPTH];
  logic [FW-1:0]    rdata;
  logic [FW:0]      cnt;
  logic [FW:0]      rp;
  logic [FW:0]      wp;
  logic             pend;
  logic [FW-1:0]    paddr;
  logic [FW-1:0]    key;
  bfm_pkg::lru_op_t op;
  logic             done;

  logic          match;
  logic          ren;
  logic          we;
  logic [FW-1:0] waddr;
  logic [FW-1:0] wdata;

  always_comb begin
    match = 1'b0;
    ren   = 1'b0;
    we    = 1'b0;
    waddr = wp[FW-1:0];
    wdata = rdata;
    case (state)
      L_IDLE: begin
        if (cmd.start && cmd.op == bfm_pkg::LRU_PUSH) begin
          we    = 1'b1;
          waddr = cnt[FW-1:0];
          wdata = frame;
        end
      end
      L_SCAN: begin
        match = pend && (op == bfm_pkg::LRU_POP || rdata == key);
        ren   = !match && (rp < cnt);
      end
      L_SHIFT: begin
        // move entry rp-1 down to wp, one per cycle
        we  = pend;
        ren = rp < cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ren) rdata <= mem[rp[FW-1:0]];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (cmd.start) begin
            op   <= cmd.op;
            key  <= frame;
            rp   <= '0;
            pend <= 1'b0;
            if (cmd.op == bfm_pkg::LRU_PUSH) begin
              cnt  <= cnt + 1'b1;
              done <= 1'b1;
            end else begin
              state <= L_SCAN;
            end
          end
        end
        L_SCAN: begin
          if (match) begin
            head  <= rdata;
            wp    <= {1'b0, paddr};
            rp    <= {1'b0, paddr} + 1'b1;
            pend  <= 1'b0;
            state <= L_SHIFT;
          end else if (ren) begin
            pend  <= 1'b1;
            paddr <= rp[FW-1:0];
            rp    <= rp + 1'b1;
          end else begin
            // not in the order, nothing to do
            pend  <= 1'b0;
            done  <= 1'b1;
            state <= L_IDLE;
          end
        end
        L_SHIFT: begin
          if (pend) wp <= wp + 1'b1;
          if (ren) begin
            pend <= 1'b1;
            rp   <= rp + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              cnt   <= cnt - 1'b1;
              done  <= 1'b1;
              state <= L_IDLE;
            end
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != L_IDLE);
  assign stat.done = done;
  assign count     = cnt;

endmodule

@@ hdl/buffer_pool_frame_manager_unit.sv @@
// Buffer pool frame manager. Requests are handled one at a time: a request is
// taken only while the block is idle. Page lookup walks the frame table memory
// one frame per cycle, and fetch, unpin, delete and flush act on what that walk
// finds. A fetch miss or a new page then takes a victim, and taking a victim
// from the lru order or removing a frame from it waits on the order memory,
// which is searched and shifted one entry per cycle. Flush all walks the table
// twice (count, then emit). A result that is not taken holds the next one,
// and the block with it, in the emit state. No clearing pass after reset.
// depends on bfm_pkg, bfm_lru and assert_macros.svh
`include "assert_macros.svh"

module buffer_pool_frame_manager_unit #(
  parameter int PIN_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  bfm_pkg::req_t     req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bfm_pkg::rsp_t     rsp
);

  localparam int NF = bfm_pkg::NUM_FRAMES;
  localparam int FW = $clog2(NF);
  localparam int EW = 31 + PIN_BITS + 1;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
  localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_EXEC, S_VICT, S_VFS, S_VLRU, S_VRD, S_VUPD,
    S_LRUW, S_FA_CNT, S_FA_SCAN, S_EMIT
  } state_t;

  state_t state;

  logic [4:0]  icount;
  logic [3:0]  inum;
  logic [30:0] next_page;

  bfm_pkg::req_t req_q;
  bfm_pkg::rsp_t res;
  bfm_pkg::rsp_t rsp_q;
  logic          rsp_v;
  logic          rsp_load;
  logic          fa_more;

  logic [FW:0]   sidx;
  logic          spend;
  logic [FW-1:0] spaddr;
  logic          hit;
  logic [FW-1:0] hf;
  logic [FW-1:0] vf;
  logic [FW:0]   nd;
  logic [FW:0]   ne;

  // frame table: {page, pin count, dirty}; valid bits in flops
  logic [EW-1:0]        fmem [NF];
  logic [EW-1:0]        frd;
  logic [NF-1:0]        fvalid;
  logic                 fm_ren;
  logic [FW-1:0]        fm_raddr;
  logic                 fm_we;
  logic [FW-1:0]        fm_waddr;
  logic [EW-1:0]        fm_wdata;

  // free stack; an entry never written holds its own index
  logic [FW-1:0]        fs_mem [NF];
  logic [NF-1:0]        fs_wv;
  logic [FW:0]          free_cnt;
  logic [FW-1:0]        fs_rdata;
  logic                 fs_rv;
  logic [FW-1:0]        fs_ridx;
  logic                 fs_ren;
  logic [FW-1:0]        fs_raddr;
  logic                 fs_we;

  bfm_pkg::lru_cmd_t  lru_cmd;
  bfm_pkg::lru_stat_t lru_st;
  logic [FW-1:0]      lru_head;
  logic [FW:0]        lru_cnt;

  logic [30:0]         e_page;
  logic [PIN_BITS-1:0] e_pin;
  logic                e_dirty;
  logic                scan_hit;
  logic                scan_more;
  logic [30:0]         np;
  logic                cfg_we;

  assign e_page   = frd[EW-1 -: 31];
  assign e_pin    = frd[PIN_BITS:1];
  assign e_dirty  = frd[0];
  assign np       = (req_q.mode == bfm_pkg::MODE_NEW) ? next_page : req_q.page_id;
  assign cfg_we   = psel && penable && pwrite;
  assign rsp_load = (state == S_EMIT) && (!rsp_v || rsp_ready);

  function automatic bfm_pkg::rsp_t mk_rsp(bfm_pkg::status_t st, logic [FW-1:0] fr,
                                           logic [30:0] pg, logic wb, logic [30:0] wbp,
                                           logic rd, logic lst);
    bfm_pkg::rsp_t r;
    r.status          = st;
    r.frame           = 4'(fr);
    r.page_out        = pg;
    r.write_back      = wb;
    r.write_back_page = wb ? wbp : 31'd0;
    r.read_in         = rd;
    r.last            = lst;
    return r;
  endfunction

  bfm_lru #(.DEPTH(NF)) u_lru (
    .clk   (clk),
    .rst   (rst),
    .cmd   (lru_cmd),
    .frame (hf),
    .stat  (lru_st),
    .head  (lru_head),
    .count (lru_cnt)
  );

  always_comb begin
    scan_more = (sidx < (FW+1)'(NF));
    scan_hit  = 1'b0;
    case (state)
      S_FIND:              scan_hit = spend && fvalid[spaddr] && e_page == req_q.page_id;
      S_FA_CNT, S_FA_SCAN: scan_hit = spend && fvalid[spaddr] && e_dirty;
      default: ;
    endcase

    fm_ren   = 1'b0;
    fm_raddr = sidx[FW-1:0];
    fm_we    = 1'b0;
    fm_waddr = hf;
    fm_wdata = frd;
    fs_ren   = 1'b0;
    fs_raddr = fs_ridx;
    fs_we    = 1'b0;
    lru_cmd.start = 1'b0;
    lru_cmd.op    = bfm_pkg::LRU_REMOVE;

    case (state)
      S_FIND, S_FA_SCAN: fm_ren = !scan_hit && scan_more;
      S_FA_CNT:          fm_ren = scan_more;
      S_VRD: begin
        fm_ren   = 1'b1;
        fm_raddr = vf;
      end
      S_EXEC: begin
        case (req_q.mode)
          bfm_pkg::MODE_FETCH: begin
            if (hit && e_pin != PIN_MAX) begin
              fm_we    = 1'b1;
              fm_wdata = {e_page, e_pin + 1'b1, e_dirty};
              lru_cmd.start = (e_pin == '0);
            end
          end
          bfm_pkg::MODE_UNPIN: begin
            if (hit && e_pin != '0) begin
              fm_we    = 1'b1;
              fm_wdata = {e_page, e_pin - 1'b1, e_dirty | req_q.mark_dirty};
              lru_cmd.start = (e_pin == PIN_ONE);
              lru_cmd.op    = bfm_pkg::LRU_PUSH;
            end
          end
          bfm_pkg::MODE_DELETE: begin
            if (hit && e_pin == '0) begin
              fs_we         = (free_cnt < (FW+1)'(NF));
              lru_cmd.start = 1'b1;
            end
          end
          bfm_pkg::MODE_FLUSH: begin
            if (hit) begin
              fm_we    = 1'b1;
              fm_wdata = {e_page, e_pin, 1'b0};
            end
          end
          default: ;
        endcase
      end
      S_VICT: begin
        if (free_cnt != '0) begin
          fs_ren   = 1'b1;
          fs_raddr = free_cnt[FW-1:0] - 1'b1;
        end else if (lru_cnt != '0) begin
          lru_cmd.start = 1'b1;
          lru_cmd.op    = bfm_pkg::LRU_POP;
        end
      end
      S_VUPD: begin
        fm_we    = 1'b1;
        fm_waddr = vf;
        fm_wdata = {np, PIN_ONE, 1'b0};
      end
      default: ;
    endcase

    // flush all clears each dirty bit as its result is produced
    if (state == S_FA_SCAN && scan_hit) begin
      fm_we    = 1'b1;
      fm_waddr = spaddr;
      fm_wdata = {e_page, e_pin, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (fm_ren) frd <= fmem[fm_raddr];
    if (fm_we) fmem[fm_waddr] <= fm_wdata;
    if (fs_ren) begin
      fs_rdata <= fs_mem[fs_raddr];
      fs_ridx  <= fs_raddr;
    end
    if (fs_we) fs_mem[free_cnt[FW-1:0]] <= hf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      icount    <= 5'd1;
      inum      <= 4'd0;
      next_page <= '0;
      rsp_v     <= 1'b0;
      fa_more   <= 1'b0;
      spend     <= 1'b0;
      fvalid    <= '0;
      fs_wv     <= '0;
      fs_rv     <= 1'b0;
      free_cnt  <= (FW+1)'(NF);
    end else begin
      if (cfg_we) begin
        case (paddr[2])
          bfm_pkg::REG_INST_COUNT: icount <= pwdata[4:0];
          bfm_pkg::REG_INST_NUMBER: begin
            inum      <= pwdata[3:0];
            next_page <= 31'(pwdata[3:0]);
          end
          default: ;
        endcase
      end

      if (fs_ren) fs_rv <= fs_wv[fs_raddr];
      if (fs_we) begin
        fs_wv[free_cnt[FW-1:0]] <= 1'b1;
        free_cnt <= free_cnt + 1'b1;
      end

      if (rsp_load) rsp_v <= 1'b1;
      else if (rsp_ready) rsp_v <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q   <= req;
            sidx    <= '0;
            spend   <= 1'b0;
            nd      <= '0;
            ne      <= '0;
            fa_more <= 1'b0;
            case (req.mode)
              bfm_pkg::MODE_FETCH, bfm_pkg::MODE_UNPIN,
              bfm_pkg::MODE_DELETE, bfm_pkg::MODE_FLUSH: state <= S_FIND;
              bfm_pkg::MODE_NEW:       state <= S_VICT;
              bfm_pkg::MODE_FLUSH_ALL: state <= S_FA_CNT;
              default: ;
            endcase
          end
        end
        S_FIND: begin
          if (scan_hit) begin
            hit   <= 1'b1;
            hf    <= spaddr;
            spend <= 1'b0;
            state <= S_EXEC;
          end else if (fm_ren) begin
            spend  <= 1'b1;
            spaddr <= sidx[FW-1:0];
            sidx   <= sidx + 1'b1;
          end else begin
            hit   <= 1'b0;
            spend <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_EMIT;
          case (req_q.mode)
            bfm_pkg::MODE_FETCH: begin
              if (!hit) begin
                state <= S_VICT;
              end else if (e_pin == PIN_MAX) begin
                res <= mk_rsp(bfm_pkg::ST_PINNED, hf, req_q.page_id, 1'b0, '0, 1'b0, 1'b1);
              end else begin
                res <= mk_rsp(bfm_pkg::ST_OK, hf, req_q.page_id, 1'b0, '0, 1'b0, 1'b1);
                if (e_pin == '0) state <= S_LRUW;
              end
            end
            bfm_pkg::MODE_UNPIN: begin
              if (!hit) begin
                res <= mk_rsp(bfm_pkg::ST_NOT_RESIDENT, '0, req_q.page_id, 1'b0, '0,
                              1'b0, 1'b1);
              end else if (e_pin == '0) begin
                res <= mk_rsp(bfm_pkg::ST_PINNED, hf, req_q.page_id, 1'b0, '0, 1'b0, 1'b1);
              end else begin
                res <= mk_rsp(bfm_pkg::ST_OK, hf, req_q.page_id, 1'b0, '0, 1'b0, 1'b1);
                if (e_pin == PIN_ONE) state <= S_LRUW;
              end
            end
            bfm_pkg::MODE_DELETE: begin
              if (!hit) begin
                res <= mk_rsp(bfm_pkg::ST_OK, '0, req_q.page_id, 1'b0, '0, 1'b0, 1'b1);
              end else if (e_pin != '0) begin
                res <= mk_rsp(bfm_pkg::ST_PINNED, hf, req_q.page_id, 1'b0, '0, 1'b0, 1'b1);
              end else begin
                res <= mk_rsp(bfm_pkg::ST_OK, hf, req_q.page_id, e_dirty, e_page,
                              1'b0, 1'b1);
                fvalid[hf] <= 1'b0;
                state      <= S_LRUW;
              end
            end
            default: begin
              if (!hit) begin
                res <= mk_rsp(bfm_pkg::ST_NOT_RESIDENT, '0, req_q.page_id, 1'b0, '0,
                              1'b0, 1'b1);
              end else begin
                res <= mk_rsp(bfm_pkg::ST_OK, hf, req_q.page_id, e_dirty, e_page,
                              1'b0, 1'b1);
              end
            end
          endcase
        end
        S_VICT: begin
          if (free_cnt != '0) begin
            free_cnt <= free_cnt - 1'b1;
            state    <= S_VFS;
          end else if (lru_cnt != '0) begin
            state <= S_VLRU;
          end else begin
            res <= mk_rsp(bfm_pkg::ST_NO_FRAME, '0,
                          (req_q.mode == bfm_pkg::MODE_FETCH) ? req_q.page_id : 31'd0,
                          1'b0, '0, 1'b0, 1'b1);
            state <= S_EMIT;
          end
        end
        S_VFS: begin
          vf    <= fs_rv ? fs_rdata : fs_ridx;
          state <= S_VRD;
        end
        S_VLRU: begin
          if (lru_st.done) begin
            vf    <= lru_head;
            state <= S_VRD;
          end
        end
        S_VRD: state <= S_VUPD;
        S_VUPD: begin
          fvalid[vf] <= 1'b1;
          if (req_q.mode == bfm_pkg::MODE_NEW) next_page <= next_page + 31'(icount);
          res <= mk_rsp(bfm_pkg::ST_OK, vf, np, fvalid[vf] && e_dirty, e_page,
                        req_q.mode == bfm_pkg::MODE_FETCH, 1'b1);
          state <= S_EMIT;
        end
        S_LRUW: begin
          if (lru_st.done) state <= S_EMIT;
        end
        S_FA_CNT: begin
          if (scan_hit) nd <= nd + 1'b1;
          if (fm_ren) begin
            spend  <= 1'b1;
            spaddr <= sidx[FW-1:0];
            sidx   <= sidx + 1'b1;
          end else if (spend) begin
            spend <= 1'b0;
          end else if (nd == '0) begin
            res   <= mk_rsp(bfm_pkg::ST_OK, '0, '0, 1'b0, '0, 1'b0, 1'b1);
            state <= S_EMIT;
          end else begin
            sidx  <= '0;
            state <= S_FA_SCAN;
          end
        end
        S_FA_SCAN: begin
          if (scan_hit) begin
            spend   <= 1'b0;
            ne      <= ne + 1'b1;
            fa_more <= ((ne + 1'b1) != nd);
            res     <= mk_rsp(bfm_pkg::ST_OK, spaddr, e_page, 1'b1, e_page, 1'b0,
                              (ne + 1'b1) == nd);
            state   <= S_EMIT;
          end else if (fm_ren) begin
            spend  <= 1'b1;
            spaddr <= sidx[FW-1:0];
            sidx   <= sidx + 1'b1;
          end else if (spend) begin
            spend <= 1'b0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (rsp_load) begin
            rsp_q   <= res;
            fa_more <= 1'b0;
            state   <= fa_more ? S_FA_SCAN : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bfm_pkg::REG_INST_COUNT:  prdata = 32'(icount);
      bfm_pkg::REG_INST_NUMBER: prdata = 32'(inum);
      default:                  prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = rsp_v;
  assign rsp       = rsp_q;

  // a delete frees its frame before the lru order drops it, so check only at rest
  `BFM_ASSERT_IMPL(a_pool_bound, !lru_st.busy, (32'(free_cnt) + 32'(lru_cnt)) <= NF, "pool overcount")
  `BFM_ASSERT_IMPL(a_idle_lru, state == S_IDLE, !lru_st.busy, "lru busy while idle")
  `BFM_ASSERT_NEXT(a_emit_hold, state == S_EMIT && rsp_v && !rsp_ready, state == S_EMIT, "result lost")

endmodule

@@ sim/bfm_checker.sv @@
// checker for the buffer pool frame manager: watches config writes, request and response beats
// keeps its own frame table, free stack and lru order to predict every response; needs bfm_pkg
`timescale 1ns / 100ps

module bfm_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  input  logic          req_valid,
  input  logic          req_ready,
  input  bfm_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  bfm_pkg::rsp_t rsp,
  output int            fails,
  output int            pending,
  output int            rsp_beats
);

  localparam int FRAMES    = bfm_pkg::NUM_FRAMES;
  localparam int PIN_LIMIT = 255;

  logic [4:0]    stride;
  logic [30:0]   next_id;
  logic [30:0]   page_of [FRAMES];
  logic          resident [FRAMES];
  logic          dirty [FRAMES];
  int            pins [FRAMES];
  int            free_stk [FRAMES];
  int            free_n;
  int            lru_q[$];
  bfm_pkg::rsp_t expected_rsp[$];

  function automatic void queue_rsp(bfm_pkg::status_t st, int fr, logic [30:0] pg, logic wb,
                                    logic [30:0] wbp, logic rd, logic lst);
    bfm_pkg::rsp_t r;
    r.status          = st;
    r.frame           = fr[3:0];
    r.page_out        = pg;
    r.write_back      = wb;
    r.write_back_page = wb ? wbp : '0;
    r.read_in         = rd;
    r.last            = lst;
    expected_rsp = {expected_rsp, r};
  endfunction

  function automatic int lookup(logic [30:0] pid);
    for (int i = 0; i < FRAMES; i++)
      if (resident[i] && page_of[i] == pid) return i;
    return -1;
  endfunction

  function automatic void lru_drop(int f);
    for (int i = 0; i < lru_q.size(); i++)
      if (lru_q[i] == f) begin
        lru_q.delete(i);
        return;
      end
  endfunction

  // free stack first, then least recently unpinned
  function automatic int grab_victim();
    int f;
    if (free_n > 0) begin
      free_n--;
      return free_stk[free_n];
    end
    if (lru_q.size() > 0) begin
      f = lru_q.pop_front();
      return f;
    end
    return -1;
  endfunction

  task automatic predict(input bfm_pkg::req_t r);
    int f;
    int n;
    logic wb;
    logic [30:0] np;
    case (r.mode)
      bfm_pkg::MODE_FETCH, bfm_pkg::MODE_NEW: begin
        f = (r.mode == bfm_pkg::MODE_FETCH) ? lookup(r.page_id) : -1;
        if (f >= 0) begin
          if (pins[f] >= PIN_LIMIT) begin
            queue_rsp(bfm_pkg::ST_PINNED, f, r.page_id, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            if (pins[f] == 0) lru_drop(f);
            pins[f]++;
            queue_rsp(bfm_pkg::ST_OK, f, r.page_id, 1'b0, '0, 1'b0, 1'b1);
          end
        end else begin
          f = grab_victim();
          if (f < 0) begin
            queue_rsp(bfm_pkg::ST_NO_FRAME, 0,
                      (r.mode == bfm_pkg::MODE_FETCH) ? r.page_id : '0,
                      1'b0, '0, 1'b0, 1'b1);
          end else begin
            wb = resident[f] && dirty[f];
            if (r.mode == bfm_pkg::MODE_NEW) begin
              np = next_id;
              next_id = next_id + 31'(stride);
            end else begin
              np = r.page_id;
            end
            queue_rsp(bfm_pkg::ST_OK, f, np, wb, page_of[f],
                      r.mode == bfm_pkg::MODE_FETCH, 1'b1);
            page_of[f]  = np;
            resident[f] = 1'b1;
            pins[f]     = 1;
            dirty[f]    = 1'b0;
          end
        end
      end
      bfm_pkg::MODE_UNPIN: begin
        f = lookup(r.page_id);
        if (f < 0) begin
          queue_rsp(bfm_pkg::ST_NOT_RESIDENT, 0, r.page_id, 1'b0, '0, 1'b0, 1'b1);
        end else if (pins[f] == 0) begin
          queue_rsp(bfm_pkg::ST_PINNED, f, r.page_id, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          pins[f]--;
          dirty[f] = dirty[f] | r.mark_dirty;
          if (pins[f] == 0) begin
            lru_drop(f);
            lru_q = {lru_q, f};
          end
          queue_rsp(bfm_pkg::ST_OK, f, r.page_id, 1'b0, '0, 1'b0, 1'b1);
        end
      end
      bfm_pkg::MODE_DELETE: begin
        f = lookup(r.page_id);
        if (f < 0) begin
          queue_rsp(bfm_pkg::ST_OK, 0, r.page_id, 1'b0, '0, 1'b0, 1'b1);
        end else if (pins[f] != 0) begin
          queue_rsp(bfm_pkg::ST_PINNED, f, r.page_id, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          queue_rsp(bfm_pkg::ST_OK, f, r.page_id, dirty[f], page_of[f], 1'b0, 1'b1);
          resident[f] = 1'b0;
          dirty[f]    = 1'b0;
          lru_drop(f);
          if (free_n < FRAMES) begin
            free_stk[free_n] = f;
            free_n++;
          end
        end
      end
      bfm_pkg::MODE_FLUSH: begin
        f = lookup(r.page_id);
        if (f < 0) begin
          queue_rsp(bfm_pkg::ST_NOT_RESIDENT, 0, r.page_id, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          queue_rsp(bfm_pkg::ST_OK, f, r.page_id, dirty[f], page_of[f], 1'b0, 1'b1);
          dirty[f] = 1'b0;
        end
      end
      bfm_pkg::MODE_FLUSH_ALL: begin
        n = 0;
        for (int i = 0; i < FRAMES; i++)
          if (resident[i] && dirty[i]) begin
            dirty[i] = 1'b0;
            queue_rsp(bfm_pkg::ST_OK, i, page_of[i], 1'b1, page_of[i], 1'b0, 1'b0);
            n++;
          end
        if (n == 0) queue_rsp(bfm_pkg::ST_OK, 0, '0, 1'b0, '0, 1'b0, 1'b1);
        else expected_rsp[expected_rsp.size() - 1].last = 1'b1;
      end
      default: ;  // unknown modes are dropped silently
    endcase
  endtask

  always @(posedge clk) begin
    bfm_pkg::rsp_t want;
    if (rst) begin
      stride  <= 5'd1;
      next_id = '0;
      for (int i = 0; i < FRAMES; i++) begin
        resident[i] = 1'b0;
        dirty[i]    = 1'b0;
        pins[i]     = 0;
        page_of[i]  = '0;
        free_stk[i] = i;
      end
      free_n = FRAMES;
      lru_q.delete();
      expected_rsp.delete();
      fails     <= 0;
      rsp_beats <= 0;
      pending   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bfm_pkg::REG_INST_NUMBER) begin
          next_id = 31'(pwdata[3:0]);
        end else begin
          stride <= pwdata[4:0];
        end
      end
      if (rsp_valid && rsp_ready) begin
        rsp_beats <= rsp_beats + 1;
        if (expected_rsp.size() == 0) begin
          $error("response beat with nothing expected: %p", rsp);
          fails <= fails + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp !== want) begin
            fails <= fails + 1;
            if (rsp.status !== want.status)
              $error("status: expected %0d, got %0d", want.status, rsp.status);
            if (rsp.frame !== want.frame)
              $error("frame: expected %0d, got %0d", want.frame, rsp.frame);
            if (rsp.page_out !== want.page_out)
              $error("page_out: expected %h, got %h", want.page_out, rsp.page_out);
            if (rsp.write_back !== want.write_back)
              $error("write_back: expected %b, got %b", want.write_back, rsp.write_back);
            if (rsp.write_back_page !== want.write_back_page)
              $error("write_back_page: expected %h, got %h", want.write_back_page,
                     rsp.write_back_page);
            if (rsp.read_in !== want.read_in)
              $error("read_in: expected %b, got %b", want.read_in, rsp.read_in);
            if (rsp.last !== want.last)
              $error("last: expected %b, got %b", want.last, rsp.last);
          end
        end
      end
      // predict after the config write above; the bench keeps requests off while it writes config
      if (req_valid && req_ready) predict(req);
      pending <= expected_rsp.size();
    end
  end

endmodule

@@ sim/tb.sv @@
// testbench top for buffer_pool_frame_manager_unit: clock, reset, config writes and requests
// depends on bfm_pkg, the unit under test and bfm_checker, which predicts and compares
`timescale 1ns / 100ps

module tb;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          req_valid = 1'b0;
  logic          req_ready;
  bfm_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  bfm_pkg::rsp_t rsp;
  int            fails, pending, rsp_beats;

  int          burst_left = 0;
  int          items_sent = 0;
  int          settings_used = 0;
  logic [30:0] page_set [32];

  buffer_pool_frame_manager_unit dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp
  );

  bfm_checker chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .fails, .pending, .rsp_beats
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: picks a stall style and keeps it for a random stretch
  int ready_style = 0, style_left = 0, ready_tick = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style = $urandom_range(0, 3);
        style_left  = (ready_style == 2) ? $urandom_range(1, 8) : $urandom_range(10, 60);
      end
      style_left--;
      ready_tick++;
      case (ready_style)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        2: rsp_ready <= 1'b0;
        default: rsp_ready <= ready_tick[0];
      endcase
    end
  end

  task automatic reg_write(input logic regsel, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send(input logic [2:0] m, input logic [30:0] pid, input logic md);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    req_valid <= 1'b1;
    req       <= '{mode: m, page_id: pid, mark_dirty: md};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // let the block settle before the registers change
  task automatic drain_and_set(input logic [4:0] stride, input logic [3:0] base);
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    reg_write(bfm_pkg::REG_INST_COUNT, 32'(stride));
    reg_write(bfm_pkg::REG_INST_NUMBER, 32'(base));
    settings_used++;
  endtask

  task automatic random_ops(input int count);
    logic [30:0] pid;
    int pick;
    for (int k = 0; k < count; k++) begin
      pid  = page_set[$urandom_range(0, 31)];
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // well-formed pin/unpin pair
        send(bfm_pkg::MODE_FETCH, pid, 1'b0);
        send(bfm_pkg::MODE_UNPIN, pid, 1'($urandom_range(0, 1)));
        k++;
      end else if (pick < 68) send(bfm_pkg::MODE_NEW, 31'($urandom), 1'($urandom_range(0, 1)));
      else if (pick < 76) send(bfm_pkg::MODE_FETCH, pid, 1'($urandom_range(0, 1)));
      else if (pick < 82) send(bfm_pkg::MODE_UNPIN, pid, 1'($urandom_range(0, 1)));
      else if (pick < 89) send(bfm_pkg::MODE_DELETE, pid, 1'($urandom_range(0, 1)));
      else if (pick < 94) send(bfm_pkg::MODE_FLUSH, pid, 1'($urandom_range(0, 1)));
      else if (pick < 98) send(bfm_pkg::MODE_FLUSH_ALL, 31'($urandom), 1'($urandom_range(0, 1)));
      else send(3'($urandom_range(6, 7)), pid, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    page_set[0] = '0;
    page_set[1] = 31'h7fffffff;
    for (int i = 2; i < 22; i++) page_set[i] = 31'(i - 2);
    for (int i = 22; i < 32; i++) page_set[i] = 31'($urandom);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // directed: hits, misses, pin errors, deletes, flushes, duplicate ids, unknown modes
    send(bfm_pkg::MODE_FETCH, 31'd0, 1'b0);
    send(bfm_pkg::MODE_FETCH, 31'd0, 1'b0);
    send(bfm_pkg::MODE_UNPIN, 31'd0, 1'b1);
    send(bfm_pkg::MODE_UNPIN, 31'd0, 1'b0);
    send(bfm_pkg::MODE_UNPIN, 31'd0, 1'b1);
    send(bfm_pkg::MODE_FLUSH, 31'd0, 1'b0);
    send(bfm_pkg::MODE_FLUSH, 31'h7fffffff, 1'b1);
    send(bfm_pkg::MODE_UNPIN, 31'h7fffffff, 1'b1);
    send(bfm_pkg::MODE_DELETE, 31'd5, 1'b0);
    send(bfm_pkg::MODE_FETCH, 31'h7fffffff, 1'b1);
    send(bfm_pkg::MODE_DELETE, 31'h7fffffff, 1'b0);
    send(bfm_pkg::MODE_UNPIN, 31'h7fffffff, 1'b1);
    send(bfm_pkg::MODE_DELETE, 31'h7fffffff, 1'b1);
    send(bfm_pkg::MODE_NEW, 31'h7fffffff, 1'b1);
    send(bfm_pkg::MODE_NEW, 31'd0, 1'b0);
    send(bfm_pkg::MODE_FLUSH_ALL, 31'h7fffffff, 1'b1);
    send(bfm_pkg::MODE_UNPIN, 31'd0, 1'b1);
    send(bfm_pkg::MODE_UNPIN, 31'd1, 1'b1);
    send(bfm_pkg::MODE_FETCH, 31'd0, 1'b0);
    send(3'd6, 31'h2aaaaaaa, 1'b1);
    send(3'd7, 31'h55555555, 1'b0);
    send(bfm_pkg::MODE_FLUSH_ALL, 31'd0, 1'b0);

    // pool exhaustion, then a flush all with many dirty frames
    for (int i = 0; i < 20; i++) send(bfm_pkg::MODE_FETCH, 31'(100 + i), 1'b0);
    for (int i = 0; i < 20; i++) send(bfm_pkg::MODE_UNPIN, 31'(100 + i), i[0]);
    send(bfm_pkg::MODE_FLUSH_ALL, 31'd0, 1'b0);

    drain_and_set(5'd16, 4'd15);
    random_ops(12);
    drain_and_set(5'd0, 4'd0);
    random_ops(12);
    drain_and_set(5'($urandom_range(1, 3)), 4'($urandom_range(0, 15)));
    random_ops(12);
    drain_and_set(5'($urandom_range(1, 16)), 4'($urandom_range(0, 15)));
    random_ops(12);

    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("run covered %0d requests and %0d response beats under %0d register settings",
             items_sent, rsp_beats, settings_used);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatching beats", fails);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

endmodule
